// ----- rtl/core/bgi_pkg.sv -----
// Shared types, codes and sizes of the bilinear grid interpolator.
package bgi_pkg;

    // Default grid extents
    localparam int R_POINTS_MAX_DEF = 64;
    localparam int Z_POINTS_MAX_DEF = 64;

    // Fixed field widths
    localparam int LEN_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Iterative units
    localparam int SQRT_STEPS = 32;
    localparam int DIV_NUM_W  = 49;
    localparam int DIV_DEN_W  = 33;

    // Q1.16 unit weight
    localparam logic [16:0] W_ONE = 17'd65536;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_R_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd2;

    // Command codes
    typedef enum logic [1:0] {
        CMD_LOAD_R    = 2'd0,
        CMD_LOAD_Z    = 2'd1,
        CMD_LOAD_GRID = 2'd2,
        CMD_QUERY     = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         row;
        logic [5:0]         column;
        logic signed [31:0] axis_value;
        logic signed [31:0] radial_value;
        logic signed [31:0] toroidal_value;
        logic signed [31:0] vertical_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] radial_out;
        logic signed [31:0] toroidal_out;
        logic signed [31:0] vertical_out;
        logic               result_valid;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0] r_len;
        logic [LEN_W-1:0] z_len;
        logic             three_d;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- rtl/core/bgi_front.sv -----
// Front end: accepts commands and drops loads that fall outside the stores.
module bgi_front #(
    parameter int R_POINTS_MAX = bgi_pkg::R_POINTS_MAX_DEF,
    parameter int Z_POINTS_MAX = bgi_pkg::Z_POINTS_MAX_DEF
) (
    input  logic               start,
    output logic               busy,
    input  bgi_pkg::t_in_item  i_item,
    input  bgi_pkg::t_q_status i_q_status,
    output logic               o_push,
    output bgi_pkg::t_in_item  o_item
);
    import bgi_pkg::*;

    logic accept;
    logic keep;

    // Hold off new commands while the queue is full
    assign busy   = i_q_status.full;
    assign accept = start & ~i_q_status.full;
    assign o_item = i_item;

    // Classify: loads beyond the store depth are dropped here
    always_comb begin
        unique case (i_item.command)
            CMD_LOAD_R:    keep = 32'(i_item.row) < R_POINTS_MAX;
            CMD_LOAD_Z:    keep = 32'(i_item.row) < Z_POINTS_MAX;
            CMD_LOAD_GRID: keep = (32'(i_item.row) < Z_POINTS_MAX)
                               && (32'(i_item.column) < R_POINTS_MAX);
            CMD_QUERY:     keep = 1'b1;
            default:       keep = 1'b0;
        endcase
    end

    assign o_push = accept & keep;

endmodule

// ----- rtl/core/bgi_fifo.sv -----
// Short command queue between the front end and the back end.
module bgi_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bgi_pkg::t_in_item  i_item,
    input  logic               i_pop,
    output bgi_pkg::t_in_item  o_item,
    output bgi_pkg::t_q_status o_status
);
    import bgi_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_in_item        r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        begin
            f_next = (32'(p) == QUEUE_DEPTH - 1) ? '0 : PW'(32'(p) + 1);
        end
    endfunction

    assign o_item         = r_mem[r_rp];
    assign o_status.full  = (32'(r_cnt) == QUEUE_DEPTH);
    assign o_status.empty = (r_cnt == '0);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= f_next(r_wp);
            if (i_pop)  r_rp <= f_next(r_rp);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - CW'(1);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ----- rtl/core/bgi_div.sv -----
// Restoring divider, one quotient bit per cycle.
module bgi_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bgi_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [bgi_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_busy,
    output logic [bgi_pkg::DIV_NUM_W-1:0] o_quot
);
    import bgi_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    assign trial  = {r_rem, r_q[DIV_NUM_W-1]};
    assign ge     = trial >= {1'b0, r_den};
    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIV_NUM_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Shift in one numerator bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (o_busy) begin
            r_rem <= ge ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
            r_q   <= {r_q[DIV_NUM_W-2:0], ge};
        end
    end

endmodule

// ----- rtl/core/bgi_sqrt.sv -----
// Integer square root, two radicand bits per cycle.
module bgi_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_busy,
    output logic [31:0] o_root
);
    import bgi_pkg::*;

    localparam int CNT_W = $clog2(SQRT_STEPS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_rad;
    logic [33:0]      r_rem;
    logic [31:0]      r_root;
    logic [35:0]      rem_sh;
    logic [35:0]      trial;
    logic             ge;

    assign rem_sh = {r_rem, r_rad[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = rem_sh >= trial;
    assign o_busy = (r_cnt != '0);
    assign o_root = r_root;

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(SQRT_STEPS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Resolve one root bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (o_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= ge ? 34'(rem_sh - trial) : 34'(rem_sh);
            r_root <= {r_root[30:0], ge};
        end
    end

endmodule

// ----- rtl/core/bgi_back.sv -----
// Back end: stores, axis scans, weights and the blend of the four corners.
module bgi_back #(
    parameter int R_POINTS_MAX = bgi_pkg::R_POINTS_MAX_DEF,
    parameter int Z_POINTS_MAX = bgi_pkg::Z_POINTS_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bgi_pkg::t_q_status i_q_status,
    output logic               o_pop,
    input  bgi_pkg::t_in_item  i_item,
    input  bgi_pkg::t_cfg      i_cfg,
    output logic               o_strobe,
    output bgi_pkg::t_out_item o_result
);
    import bgi_pkg::*;

    localparam int PMAX = (R_POINTS_MAX > Z_POINTS_MAX) ? R_POINTS_MAX : Z_POINTS_MAX;
    localparam int AW   = $clog2(PMAX);
    localparam int NW   = $clog2(PMAX + 1);
    localparam int RAW  = $clog2(R_POINTS_MAX);
    localparam int ZAW  = $clog2(Z_POINTS_MAX);
    localparam int GN   = R_POINTS_MAX * Z_POINTS_MAX;
    localparam int GAW  = $clog2(GN);

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_EXEC   = 18'h00002,
        S_SQA    = 18'h00004,
        S_SQB    = 18'h00008,
        S_SQC    = 18'h00010,
        S_SQRT   = 18'h00020,
        S_AX0    = 18'h00040,
        S_AX1    = 18'h00080,
        S_AX2    = 18'h00100,
        S_SCAN   = 18'h00200,
        S_LO     = 18'h00400,
        S_HI     = 18'h00800,
        S_DIV    = 18'h01000,
        S_WAIT   = 18'h02000,
        S_CORNER = 18'h04000,
        S_MAC    = 18'h08000,
        S_DRAIN  = 18'h10000,
        S_OUT    = 18'h20000
    } t_state;

    t_state r_state, n_state;
    logic   r_strobe, n_strobe;
    logic   r_pv;

    // Stores
    logic signed [31:0] r_raxis [R_POINTS_MAX];
    logic signed [31:0] r_zaxis [Z_POINTS_MAX];
    logic signed [31:0] r_grid_r [GN];
    logic signed [31:0] r_grid_t [GN];
    logic signed [31:0] r_grid_v [GN];
    logic signed [31:0] r_ra_data, r_za_data;
    logic signed [31:0] r_gr_data, r_gt_data, r_gv_data;

    // Datapath registers
    t_in_item           r_cur;
    t_out_item          r_out;
    logic signed [32:0] r_rc, r_zc, r_c;
    logic               r_ax;
    logic [AW-1:0]      r_idx, r_hi, r_ir, r_iz;
    logic signed [31:0] r_lo;
    logic               r_neg, r_flat;
    logic [16:0]        r_t, r_u;
    logic [1:0]         r_k, r_j, r_pj;
    logic [32:0]        r_w;
    logic signed [65:0] r_prod;
    logic signed [65:0] r_acc [3];
    logic [63:0]        r_sq, r_sq2;

    // Combinational helpers
    logic [NW-1:0]        nr, nz, n_cur;
    logic [AW-1:0]        last, a_raddr, g_row, g_col;
    logic                 short_ax, is_query, scan_hit, den_zero, fin_axis;
    logic signed [31:0]   a_rdata, g_sel;
    logic signed [32:0]   a_val, den_s;
    logic signed [33:0]   num_s;
    logic [32:0]          num_mag, den_mag;
    logic [16:0]          div_w, w_new, fa, fb;
    logic [33:0]          w_prod;
    logic [32:0]          w_k;
    logic [GAW-1:0]       g_waddr, g_raddr;
    logic                 ra_we, za_we, gw_en;
    logic                 div_start, div_busy, sq_start, sq_busy;
    logic [DIV_NUM_W-1:0] div_q;
    logic [31:0]          sq_root;

    function automatic logic signed [31:0] f_round_sat(input logic signed [65:0] acc);
        logic signed [65:0] s;
        logic signed [33:0] q;
        begin
            s = acc + 66'sd2147483648;
            q = s[65:32];
            if (q > 34'sd2147483647)       f_round_sat = 32'sh7FFFFFFF;
            else if (q < -34'sd2147483648) f_round_sat = 32'sh80000000;
            else                           f_round_sat = q[31:0];
        end
    endfunction

    // Axis lengths in use
    assign nr = (32'(i_cfg.r_len) > R_POINTS_MAX) ? NW'(R_POINTS_MAX) : NW'(i_cfg.r_len);
    assign nz = (32'(i_cfg.z_len) > Z_POINTS_MAX) ? NW'(Z_POINTS_MAX) : NW'(i_cfg.z_len);
    assign short_ax = (32'(nr) < 2) || (32'(nz) < 2);
    assign n_cur    = r_ax ? nz : nr;
    assign last     = AW'(n_cur - NW'(1));
    assign is_query = (r_cur.command == CMD_QUERY);

    // Axis read data and search
    assign a_rdata  = r_ax ? r_za_data : r_ra_data;
    assign a_val    = 33'(a_rdata);
    assign scan_hit = (a_val >= r_c) || (r_idx == last);

    // Weight numerator and denominator
    assign num_s    = 34'(r_c) - 34'(r_lo);
    assign den_s    = a_val - 33'(r_lo);
    assign den_zero = (den_s == '0);
    assign num_mag  = num_s[33] ? 33'(-num_s) : num_s[32:0];
    assign den_mag  = den_s[32] ? 33'(-den_s) : 33'(den_s);
    assign div_w    = r_neg ? '0
                    : (div_q > DIV_NUM_W'(W_ONE)) ? W_ONE : div_q[16:0];
    assign fin_axis = ((r_state == S_DIV) && den_zero) || ((r_state == S_WAIT) && !div_busy);
    assign w_new    = (r_state == S_DIV) ? '0 : div_w;

    // Corner weight
    assign fa     = r_k[0] ? r_t : W_ONE - r_t;
    assign fb     = r_k[1] ? r_u : W_ONE - r_u;
    assign w_prod = 34'(fa) * 34'(fb);
    assign w_k    = r_flat ? ((r_k == 2'd0) ? 33'h100000000 : '0) : w_prod[32:0];

    // Grid addresses
    assign g_row   = r_k[1] ? r_iz : r_iz - AW'(1);
    assign g_col   = r_k[0] ? r_ir : r_ir - AW'(1);
    assign g_raddr = GAW'(32'(g_row) * R_POINTS_MAX + 32'(g_col));
    assign g_waddr = GAW'(32'(r_cur.row) * R_POINTS_MAX + 32'(r_cur.column));

    // Component select for the shared multiplier
    always_comb begin
        unique case (r_j)
            2'd0:    g_sel = r_gr_data;
            2'd1:    g_sel = r_gt_data;
            default: g_sel = r_gv_data;
        endcase
    end

    // Axis read address by step
    always_comb begin
        unique case (r_state)
            S_AX1:   a_raddr = last;
            S_SCAN:  a_raddr = r_idx + AW'(1);
            S_LO:    a_raddr = r_hi - AW'(1);
            S_HI:    a_raddr = r_hi;
            default: a_raddr = '0;
        endcase
    end

    assign ra_we     = (r_state == S_EXEC) && (r_cur.command == CMD_LOAD_R);
    assign za_we     = (r_state == S_EXEC) && (r_cur.command == CMD_LOAD_Z);
    assign gw_en     = (r_state == S_EXEC) && (r_cur.command == CMD_LOAD_GRID);
    assign div_start = (r_state == S_DIV) && !den_zero;
    assign sq_start  = (r_state == S_SQC);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        o_pop    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!is_query)        n_state = S_IDLE;
                else if (short_ax) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
                else if (i_cfg.three_d) n_state = S_SQA;
                else                    n_state = S_AX0;
            end
            S_SQA:  n_state = S_SQB;
            S_SQB:  n_state = S_SQC;
            S_SQC:  n_state = S_SQRT;
            S_SQRT: if (!sq_busy) n_state = S_AX0;
            S_AX0:  n_state = S_AX1;
            S_AX1:  n_state = S_AX2;
            S_AX2:  n_state = S_SCAN;
            S_SCAN: if (scan_hit) n_state = S_LO;
            S_LO:   n_state = S_HI;
            S_HI:   n_state = S_DIV;
            S_DIV: begin
                if (!den_zero) n_state = S_WAIT;
                else           n_state = r_ax ? S_CORNER : S_AX0;
            end
            S_WAIT: if (!div_busy) n_state = r_ax ? S_CORNER : S_AX0;
            S_CORNER: n_state = S_MAC;
            S_MAC: begin
                if (r_j == 2'd2) n_state = (r_k == 2'd3) ? S_DRAIN : S_CORNER;
            end
            S_DRAIN: n_state = S_OUT;
            S_OUT: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pv     <= (r_state == S_MAC);
        end
    end

    // Axis stores
    always_ff @(posedge i_clk) begin
        if (ra_we) r_raxis[RAW'(r_cur.row)] <= r_cur.axis_value;
        if (za_we) r_zaxis[ZAW'(r_cur.row)] <= r_cur.axis_value;
        r_ra_data <= r_raxis[RAW'(a_raddr)];
        r_za_data <= r_zaxis[ZAW'(a_raddr)];
    end

    // Grid stores
    always_ff @(posedge i_clk) begin
        if (gw_en) begin
            r_grid_r[g_waddr] <= r_cur.radial_value;
            r_grid_t[g_waddr] <= r_cur.toroidal_value;
            r_grid_v[g_waddr] <= r_cur.vertical_value;
        end
        r_gr_data <= r_grid_r[g_raddr];
        r_gt_data <= r_grid_t[g_raddr];
        r_gv_data <= r_grid_v[g_raddr];
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (r_pv) r_acc[r_pj] <= r_acc[r_pj] + r_prod;
        if (fin_axis) begin
            if (!r_ax) begin
                r_t  <= w_new;
                r_ir <= r_hi;
                r_ax <= 1'b1;
            end else begin
                r_u   <= w_new;
                r_iz  <= r_hi;
                r_k   <= '0;
                r_acc <= '{default: '0};
            end
        end
        unique case (r_state)
            S_IDLE: r_cur <= i_item;
            S_EXEC: begin
                r_rc   <= 33'(r_cur.point_x);
                r_zc   <= i_cfg.three_d ? 33'(r_cur.point_z) : 33'(r_cur.point_y);
                r_ax   <= 1'b0;
                r_flat <= 1'b0;
                r_out  <= '0;
            end
            S_SQA:  r_sq  <= 64'(r_cur.point_x * r_cur.point_x);
            S_SQB:  r_sq2 <= 64'(r_cur.point_y * r_cur.point_y);
            S_SQRT: if (!sq_busy) r_rc <= {1'b0, sq_root};
            S_AX0:  r_c <= r_ax ? r_zc : r_rc;
            S_AX1:  if (a_val > r_c) r_c <= a_val;
            S_AX2: begin
                if (a_val < r_c) r_c <= a_val;
                r_idx <= '0;
            end
            S_SCAN: begin
                if (scan_hit) r_hi <= (r_idx == '0) ? AW'(1) : r_idx;
                else          r_idx <= r_idx + AW'(1);
            end
            S_HI:  r_lo <= a_rdata;
            S_DIV: begin
                r_neg <= num_s[33] ^ den_s[32];
                if (den_zero) r_flat <= 1'b1;
            end
            S_CORNER: begin
                r_w <= w_k;
                r_j <= '0;
            end
            S_MAC: begin
                r_prod <= $signed({1'b0, r_w}) * g_sel;
                r_pj   <= r_j;
                if (r_j == 2'd2) r_k <= r_k + 2'd1;
                else             r_j <= r_j + 2'd1;
            end
            S_OUT: begin
                r_out.radial_out   <= f_round_sat(r_acc[0]);
                r_out.toroidal_out <= f_round_sat(r_acc[1]);
                r_out.vertical_out <= f_round_sat(r_acc[2]);
                r_out.result_valid <= 1'b1;
            end
            default: ;
        endcase
    end

    bgi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({num_mag, 16'd0}),
        .i_den   (den_mag),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    bgi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_sq + r_sq2),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// ----- rtl/core/bilinear_grid_interpolator_unit.sv -----
// Top level of the bilinear grid interpolator.
//
// Commands enter on start/i_item and are taken at an edge where start is high
// and busy is low. Loads of the r axis, z axis and field grid produce no result;
// a query produces exactly one result, shown on o_result for one cycle with
// o_strobe high. The receiver cannot stall, so results are never held.
// A two-entry queue parts the command front end from the execution back end,
// so busy rises only when the queue is full.
// A load is written into its store in the back end's EXEC state. A query with
// an axis shorter than two entries answers with zeros and result_valid low.
// Otherwise a query's time is set by the linear axis scans, the 49-step divider
// used for each weight with a nonzero denominator and, in 3-D mode, the 32-step
// square root. Configuration is written through i_cfg_valid/o_cfg_ready (always
// ready); the user must write it only while the block is idle, which the block
// itself does not enforce. Reset clears the configuration, the queue and the
// sequencer; the stores are undefined until loaded.
module bilinear_grid_interpolator_unit #(
    parameter int R_POINTS_MAX = bgi_pkg::R_POINTS_MAX_DEF,
    parameter int Z_POINTS_MAX = bgi_pkg::Z_POINTS_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bgi_pkg::t_in_item             i_item,
    output logic                          o_strobe,
    output bgi_pkg::t_out_item            o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bgi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bgi_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import bgi_pkg::*;

    t_cfg      r_cfg;
    t_q_status q_status;
    t_in_item  push_item, head_item;
    logic      push, pop;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_R_LEN: r_cfg.r_len   <= i_cfg_data;
                CFG_Z_LEN: r_cfg.z_len   <= i_cfg_data;
                CFG_MODE:  r_cfg.three_d <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bgi_front #(
        .R_POINTS_MAX (R_POINTS_MAX),
        .Z_POINTS_MAX (Z_POINTS_MAX)
    ) u_front (
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    bgi_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    bgi_back #(
        .R_POINTS_MAX (R_POINTS_MAX),
        .Z_POINTS_MAX (Z_POINTS_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .o_pop      (pop),
        .i_item     (head_item),
        .i_cfg      (r_cfg),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

// ----- rtl/core/bgi_checker.sv -----
// Port-level checks of the interpolator, bound to the top level.
module bgi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               o_strobe,
    input bgi_pkg::t_out_item o_result
);
    import bgi_pkg::*;

    // An invalid result carries zeros
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.result_valid |->
            o_result.radial_out == '0 && o_result.toroidal_out == '0
            && o_result.vertical_out == '0)
        else $error("invalid result with nonzero components");

    // Reset leaves no result and busy low
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("strobe or busy after reset");

    // Results are never back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

endmodule

bind bilinear_grid_interpolator_unit bgi_checker u_bgi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
